### rtl/wpsp_pkg.sv
// ----------------------------------------------------------------------------
// WAV PCM stream parser package
// Shared types, codes and constants for the parser controller and datapath.
// ----------------------------------------------------------------------------
package wpsp_pkg;

  localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
  localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;
  localparam logic [31:0] MAGIC_FMT  = 32'h2074_6d66;
  localparam logic [31:0] MAGIC_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_LEN    = 32'd16;
  localparam logic [15:0] WIDTH_8    = 16'd8;
  localparam logic [15:0] WIDTH_16   = 16'd16;
  localparam int          LEN_W      = 32;
  localparam int          ALIGN_W    = 16;
  localparam int          OUT_DATA_W = 88;

  typedef enum logic [3:0] {
    PH_RIFF = 4'd0, PH_SIZE = 4'd1, PH_WAVE = 4'd2, PH_TAG = 4'd3, PH_LEN = 4'd4,
    PH_FMT  = 4'd5, PH_SKIP = 4'd6, PH_DATA = 4'd7, PH_DONE = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0, KIND_FORMAT = 2'd1, KIND_FINISH = 2'd2, KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE = 4'd0, ERR_RIFF = 4'd1, ERR_WAVE = 4'd2, ERR_TRUNC = 4'd3,
    ERR_FMT2 = 4'd4, ERR_NOT_PCM = 4'd5, ERR_NO_FMT_DATA = 4'd6,
    ERR_ALIGN = 4'd7, ERR_WIDTH = 4'd8, ERR_NO_FMT = 4'd9
  } err_t;

  // Parser state plus the result slots one byte fills.
  typedef struct packed {
    phase_t      phase;
    logic [31:0] fbl;
    logic [31:0] rbl;
    logic [31:0] tag;
    logic [31:0] aw;
    logic        fseen;
    logic        pend;
    logic [15:0] ch;
    logic [31:0] rate;
    logic [15:0] ba;
    logic [15:0] wid;
    logic [7:0]  low;
    logic [3:0]  err;
    logic [3:0]  sub;
    logic [1:0]  n;
    kind_t       k0;
    kind_t       k1;
    logic [15:0] s0;
    logic [15:0] s1;
    err_t        e0;
    err_t        e1;
  } wk_t;

  typedef struct packed {
    logic load;      // capture the incoming byte
    logic div_start; // launch the remainder check
    logic step;      // apply the byte to the parser state
    logic emit_next; // advance to the next result slot
    logic emit_done; // last result taken
  } cmd_t;

  typedef struct packed {
    logic       need_mod;
    logic       div_done;
    logic [1:0] n;
    logic       slot;
  } sts_t;

endpackage

### rtl/wav_pcm_stream_parser_unit.sv
// ----------------------------------------------------------------------------
// WAV PCM stream parser
// Parses a little-endian RIFF/WAVE byte stream and emits format, samples,
// finish and error transfers.
// ----------------------------------------------------------------------------
// One byte is taken per transfer on the slave side. Each byte passes through
// capture, check, update and first result, then one further output step per
// result it causes beyond the first, and at most two results come from one byte.
// The length word of a data chunk header also passes through a bit-serial
// remainder unit against the block align before its update.
// Results are presented on the master side with the held fmt fields; tlast
// marks the final result caused by a byte. After an end-of-stream byte the
// parser restarts for a new file; after an error or a finish, bytes until
// end of stream are dropped without result.
module wav_pcm_stream_parser_unit
  import wpsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,  // [7:0] data_byte
  input  logic                  s_tlast,  // end_of_stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [15:0] sample_value, [31:16] channel_count, [63:32] sample_rate,
  // [79:64] bits_per_sample, [83:80] error_code, [87:84] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [1:0]            m_tuser,  // [1:0] kind
  output logic                  m_tlast   // last_result
);

  cmd_t cmd;
  sts_t sts;

  // sequence each byte through load, check, update and output
  wpsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // parse state, held format fields and the two result slots
  wpsp_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_byte  (s_tdata),
    .in_eos   (s_tlast),
    .out_data (m_tdata),
    .out_kind (m_tuser),
    .out_last (m_tlast)
  );

endmodule

### rtl/wpsp_rem.sv
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring remainder of a 32-bit length by a 16-bit block align, one bit per
// cycle; flags a zero remainder.
// ----------------------------------------------------------------------------
module wpsp_rem
  import wpsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [LEN_W-1:0]   dividend,
  input  logic [ALIGN_W-1:0] divisor,
  output logic               done,
  output logic               rem_zero
);

  logic [LEN_W-1:0]   shreg;
  logic [ALIGN_W:0]   rem;
  logic [5:0]         cnt;
  logic               busy;
  logic [ALIGN_W:0]   trial;

  always_comb begin
    trial = {rem[ALIGN_W-1:0], shreg[LEN_W-1]};
  end

  assign rem_zero = (rem == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 6'(LEN_W);
        shreg <= dividend;
        rem   <= '0;
      end else if (busy) begin
        // shift in one dividend bit, subtract when it fits
        if (trial >= {1'b0, divisor}) rem <= trial - {1'b0, divisor};
        else rem <= trial;
        shreg <= {shreg[LEN_W-2:0], 1'b0};
        cnt   <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/wpsp_ctrl.sv
// ----------------------------------------------------------------------------
// Parser controller
// Sequences load, optional remainder check, state update and result output.
// ----------------------------------------------------------------------------
module wpsp_ctrl
  import wpsp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_DIV, ST_STEP, ST_EMIT
  } state_t;

  state_t state;

  assign s_tready = (state == ST_IDLE);
  // present a result only when the byte caused one
  assign m_tvalid = (state == ST_EMIT) && (sts.n != 2'd0);

  always_comb begin
    cmd = '0;
    cmd.load      = (state == ST_IDLE) && s_tvalid;
    cmd.div_start = (state == ST_CHECK) && sts.need_mod;
    cmd.step      = (state == ST_STEP);
    cmd.emit_next = m_tvalid && m_tready;
    cmd.emit_done = cmd.emit_next && ({1'b0, sts.slot} == sts.n - 2'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE:  if (s_tvalid) state <= ST_CHECK;
        ST_CHECK: state <= sts.need_mod ? ST_DIV : ST_STEP;
        ST_DIV:   if (sts.div_done) state <= ST_STEP;
        ST_STEP:  state <= ST_EMIT;
        ST_EMIT: begin
          if (sts.n == 2'd0 || cmd.emit_done) state <= ST_IDLE;
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/wpsp_dpath.sv
// ----------------------------------------------------------------------------
// Parser datapath
// Holds the parse state and result slots and applies one byte per step.
// ----------------------------------------------------------------------------
module wpsp_dpath
  import wpsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [7:0]            in_byte,
  input  logic                  in_eos,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic [1:0]            out_kind,
  output logic                  out_last
);

  function automatic wk_t put(wk_t w, kind_t k, logic [15:0] smp, err_t e);
    wk_t r;
    r = w;
    if (w.n == 2'd0) begin
      r.k0 = k; r.s0 = smp; r.e0 = e; r.n = 2'd1;
    end else if (w.n == 2'd1) begin
      r.k1 = k; r.s1 = smp; r.e1 = e; r.n = 2'd2;
    end
    return r;
  endfunction

  function automatic wk_t fail(wk_t w, err_t e);
    wk_t r;
    r = w;
    r.err = e;
    r = put(r, KIND_ERROR, 16'd0, e);
    r.phase = PH_DONE;
    return r;
  endfunction

  function automatic wk_t boundary(wk_t w);
    wk_t r;
    r = w;
    if (w.rbl == '0) begin
      if (w.fseen) begin
        r = put(r, KIND_FINISH, 16'd0, ERR_NONE);
        r.phase = PH_DONE;
      end else begin
        r = fail(r, ERR_NO_FMT);
      end
    end else begin
      r.phase = PH_TAG;
      r.sub = '0;
    end
    return r;
  endfunction

  function automatic wk_t step(wk_t s, logic [7:0] b, logic eos, logic mod_zero);
    wk_t w;
    w = s;
    w.n = 2'd0;
    if (w.phase != PH_DONE) begin
      w.aw = {b, s.aw[31:8]};
      if (w.phase >= PH_WAVE && w.rbl != '0) w.rbl = w.rbl - 32'd1;
      unique case (w.phase)
        PH_RIFF: begin
          w.sub = w.sub + 4'd1;
          if (w.sub == 4'd4) begin
            w.sub = '0;
            if (w.aw != MAGIC_RIFF) w = fail(w, ERR_RIFF);
            else w.phase = PH_SIZE;
          end
        end
        PH_SIZE: begin
          w.sub = w.sub + 4'd1;
          if (w.sub == 4'd4) begin
            w.sub = '0;
            w.rbl = w.aw;
            w.phase = PH_WAVE;
          end
        end
        PH_WAVE: begin
          w.sub = w.sub + 4'd1;
          if (w.sub == 4'd4) begin
            w.sub = '0;
            if (w.aw != MAGIC_WAVE) w = fail(w, ERR_WAVE);
            else w = boundary(w);
          end
        end
        PH_TAG: begin
          w.sub = w.sub + 4'd1;
          if (w.sub == 4'd4) begin
            w.sub = '0;
            w.tag = w.aw;
            w.phase = PH_LEN;
          end
        end
        PH_LEN: begin
          w.sub = w.sub + 4'd1;
          if (w.sub == 4'd4) begin
            w.sub = '0;
            w.fbl = w.aw;
            if (w.tag == MAGIC_FMT) begin
              if (w.aw < FMT_LEN) w = fail(w, ERR_TRUNC);
              else if (w.fseen) w = fail(w, ERR_FMT2);
              else w.phase = PH_FMT;
            end else if (w.tag == MAGIC_DATA) begin
              if (!w.fseen) w = fail(w, ERR_NO_FMT_DATA);
              else if (w.ba == '0 || !mod_zero) w = fail(w, ERR_ALIGN);
              else if (w.wid != WIDTH_8 && w.wid != WIDTH_16) w = fail(w, ERR_WIDTH);
              else if (w.aw == '0) w = boundary(w);
              else begin
                w.phase = PH_DATA;
                w.pend = 1'b0;
              end
            end else begin
              if (w.aw == '0) w = boundary(w);
              else w.phase = PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          w.fbl = w.fbl - 32'd1;
          unique case (w.sub)
            4'd1: begin
              if (w.aw[31:16] != 16'd1) w = fail(w, ERR_NOT_PCM);
              else w.sub = w.sub + 4'd1;
            end
            4'd3: begin
              w.ch = w.aw[31:16];
              w.sub = w.sub + 4'd1;
            end
            4'd7: begin
              w.rate = w.aw;
              w.sub = w.sub + 4'd1;
            end
            4'd13: begin
              w.ba = w.aw[31:16];
              w.sub = w.sub + 4'd1;
            end
            4'd15: begin
              w.wid = w.aw[31:16];
              w.fseen = 1'b1;
              w = put(w, KIND_FORMAT, 16'd0, ERR_NONE);
              if (w.fbl == '0) w = boundary(w);
              else w.phase = PH_SKIP;
            end
            default: w.sub = w.sub + 4'd1;
          endcase
        end
        PH_SKIP: begin
          w.fbl = w.fbl - 32'd1;
          if (w.fbl == '0) w = boundary(w);
        end
        PH_DATA: begin
          w.fbl = w.fbl - 32'd1;
          if (w.wid == WIDTH_8) begin
            w = put(w, KIND_SAMPLE, {8'd0, b}, ERR_NONE);
          end else if (!w.pend) begin
            w.low = b;
            w.pend = 1'b1;
          end else begin
            w = put(w, KIND_SAMPLE, {b, w.low}, ERR_NONE);
            w.pend = 1'b0;
          end
          if (w.fbl == '0) w = boundary(w);
        end
        default: w.phase = PH_DONE;
      endcase
    end
    if (eos && w.phase != PH_DONE) w = fail(w, ERR_TRUNC);
    return w;
  endfunction

  wk_t         st;
  wk_t         st_next;
  wk_t         st_restart;
  logic [7:0]  byte_q;
  logic        eos_q;
  logic [15:0] ch_snap;
  logic [31:0] rate_snap;
  logic [15:0] wid_snap;
  logic        slot;
  logic        div_done;
  logic        rem_zero;
  kind_t       cur_kind;
  logic [15:0] cur_smp;
  err_t        cur_err;

  wpsp_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({byte_q, st.aw[31:8]}),
    .divisor  (st.ba),
    .done     (div_done),
    .rem_zero (rem_zero)
  );

  assign st_next = step(st, byte_q, eos_q, rem_zero);

  // clean parse state that still carries the results of the final byte
  always_comb begin
    st_restart    = '0;
    st_restart.n  = st_next.n;
    st_restart.k0 = st_next.k0;
    st_restart.k1 = st_next.k1;
    st_restart.s0 = st_next.s0;
    st_restart.s1 = st_next.s1;
    st_restart.e0 = st_next.e0;
    st_restart.e1 = st_next.e1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= '0;
      slot <= 1'b0;
    end else begin
      if (cmd.step) begin
        // snapshot held format fields before an end-of-stream restart
        ch_snap   <= st_next.ch;
        rate_snap <= st_next.rate;
        wid_snap  <= st_next.wid;
        slot      <= 1'b0;
        st        <= eos_q ? st_restart : st_next;
      end else if (cmd.emit_next) begin
        slot <= ~slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_q <= in_byte;
      eos_q  <= in_eos;
    end
  end

  always_comb begin
    cur_kind = slot ? st.k1 : st.k0;
    cur_smp  = slot ? st.s1 : st.s0;
    cur_err  = slot ? st.e1 : st.e0;
  end

  assign out_kind = cur_kind;
  assign out_last = ({1'b0, slot} == st.n - 2'd1);
  assign out_data = {4'd0, cur_err, wid_snap, rate_snap, ch_snap, cur_smp};

  always_comb begin
    sts.need_mod = (st.phase == PH_LEN) && (st.sub == 4'd3) && (st.tag == MAGIC_DATA);
    sts.div_done = div_done;
    sts.n        = st.n;
    sts.slot     = slot;
  end

endmodule
